### rtl/lpts_pkg.sv
// ----------------------------------------------------------------------------
// lpts_pkg
// Shared types and constants of the LRU page tag store: sizes, function
// and status codes, request/response structs and cell control.
// ----------------------------------------------------------------------------
package lpts_pkg;

    // number of cells in the chain (store capacity)
    localparam int N_CELLS = 32;
    localparam int IDX_W   = $clog2(N_CELLS);
    localparam int CNT_W   = $clog2(N_CELLS + 1);

    // fixed field widths
    localparam int CFG_W  = 6;
    localparam int FUNC_W = 3;
    localparam int KEY_W  = 32;
    localparam int STAT_W = 2;

    // capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(32);

    // function codes
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TOUCH  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LIST   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DROP   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP     = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  file_number;
        logic [KEY_W-1:0]  page_number;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [KEY_W-1:0]  out_file;
        logic [KEY_W-1:0]  out_page;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0] file;
        logic [KEY_W-1:0] page;
    } t_key;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] file;
        logic [KEY_W-1:0] page;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic             found;
        logic             more;
        logic [KEY_W-1:0] page;
    } t_scan_res;

endpackage

### rtl/lpts_cell.sv
// ----------------------------------------------------------------------------
// lpts_cell
// One entry of the recency chain. Takes its neighbor's entry when shifted,
// and compares its own entry against the broadcast key.
// ----------------------------------------------------------------------------
module lpts_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpts_pkg::t_cell_ctl i_ctl,
    input  lpts_pkg::t_entry   i_nbr,
    input  lpts_pkg::t_key     i_key,
    output lpts_pkg::t_entry   o_ent,
    output logic               o_match
);

    logic                       r_valid;
    logic [lpts_pkg::KEY_W-1:0] r_file;
    logic [lpts_pkg::KEY_W-1:0] r_page;

    // valid bit: cleared by drop, follows neighbor on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_nbr.valid;
        end
    end

    // tag payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_file <= i_nbr.file;
            r_page <= i_nbr.page;
        end
    end

    // key compare
    assign o_match = r_valid && (r_file == i_key.file) && (r_page == i_key.page);

    assign o_ent = '{valid: r_valid, file: r_file, page: r_page};

endmodule

### rtl/lpts_scan.sv
// ----------------------------------------------------------------------------
// lpts_scan
// List sweep tracker. Watches the entry leaving the ring each sweep cycle and
// keeps the smallest and second smallest page above the last listed one.
// ----------------------------------------------------------------------------
module lpts_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic                       i_en,
    input  logic                       i_end,
    input  logic [lpts_pkg::KEY_W-1:0] i_file,
    input  lpts_pkg::t_entry           i_ent,
    output lpts_pkg::t_scan_res        o_res
);

    logic                       r_found1;
    logic                       r_found2;
    logic                       r_have_prev;
    logic [lpts_pkg::KEY_W-1:0] r_best;
    logic [lpts_pkg::KEY_W-1:0] r_second;
    logic [lpts_pkg::KEY_W-1:0] r_prev;

    logic                       n_found1;
    logic                       n_found2;
    logic [lpts_pkg::KEY_W-1:0] n_best;
    logic [lpts_pkg::KEY_W-1:0] n_second;
    logic                       w_cand;

    // candidate: same file, above the previous listed page
    assign w_cand = i_en && i_ent.valid && (i_ent.file == i_file) &&
                    (!r_have_prev || (i_ent.page > r_prev));

    // insert candidate into the two smallest
    always_comb begin
        n_found1 = r_found1;
        n_found2 = r_found2;
        n_best   = r_best;
        n_second = r_second;
        if (w_cand) begin
            if (!r_found1 || (i_ent.page < r_best)) begin
                n_second = r_best;
                n_found2 = r_found1;
                n_best   = i_ent.page;
                n_found1 = 1'b1;
            end else if (!r_found2 || (i_ent.page < r_second)) begin
                n_second = i_ent.page;
                n_found2 = 1'b1;
            end
        end
    end

    // sweep result as of this cycle
    assign o_res = '{found: n_found1, more: n_found2, page: n_best};

    // tracker control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found1    <= 1'b0;
            r_found2    <= 1'b0;
            r_have_prev <= 1'b0;
        end else if (i_clr) begin
            r_found1    <= 1'b0;
            r_found2    <= 1'b0;
            r_have_prev <= 1'b0;
        end else if (i_en) begin
            if (i_end) begin
                r_found1    <= 1'b0;
                r_found2    <= 1'b0;
                r_have_prev <= r_have_prev | n_found1;
            end else begin
                r_found1 <= n_found1;
                r_found2 <= n_found2;
            end
        end
    end

    // tracker payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_best   <= n_best;
            r_second <= n_second;
            if (i_end && n_found1) begin
                r_prev <= n_best;
            end
        end
    end

endmodule

### rtl/lru_page_tag_store_core.sv
// ----------------------------------------------------------------------------
// lru_page_tag_store_core
// Fully associative page tag directory with least-recently-used replacement,
// built as a chain of cells ordered by recency.
// ----------------------------------------------------------------------------
// Lookup, insert, touch, drop and unknown functions: the key is compared
// against all cells in the accept cycle, and the chain shifts and the result
// is registered in the next. List rotates the whole ring once per listed page
// (at least once), and results arrive one per ring rotation. busy stays high
// until the final result (last set) is on the outputs. Every result is shown on
// o_rsp for one cycle with o_done high and cannot be held off. The capacity
// register is written through i_cfg_valid/o_cfg_ready; the user must write it
// only while the block is idle, which the block itself does not enforce; its
// ready is always high.
// ----------------------------------------------------------------------------
module lru_page_tag_store_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  lpts_pkg::t_req             i_req,
    output logic                       busy,
    output logic                       o_done,
    output lpts_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lpts_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int N     = lpts_pkg::N_CELLS;
    localparam int IDX_W = lpts_pkg::IDX_W;
    localparam int CNT_W = lpts_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_done, n_done;
    lpts_pkg::t_rsp                 r_rsp, n_rsp;
    logic [lpts_pkg::FUNC_W-1:0]    r_func, n_func;
    lpts_pkg::t_key                 r_key, n_key;
    logic [N-1:0]                   r_match, n_match;
    logic [CNT_W-1:0]               r_occ, n_occ;
    logic [lpts_pkg::CFG_W-1:0]     r_cap, n_cap;
    logic [IDX_W-1:0]               r_step, n_step;

    lpts_pkg::t_entry               w_ent [N];
    logic [N-1:0]                   w_hit;
    logic [N-1:0]                   w_valid;
    lpts_pkg::t_cell_ctl            w_ctl [N];
    lpts_pkg::t_entry               w_head;
    lpts_pkg::t_key                 w_cmp_key;
    lpts_pkg::t_scan_res            w_scan;

    logic                           w_accept;
    logic                           w_rotate;
    logic                           w_upd;
    logic                           w_drop;
    logic                           w_any;
    logic [IDX_W-1:0]               w_k;
    logic [CNT_W-1:0]               w_cap_eff;
    logic                           w_full;
    logic [CNT_W-1:0]               w_occ_m1;
    logic [CNT_W-1:0]               w_bound;
    logic [N-1:0]                   w_le;
    lpts_pkg::t_entry               w_victim;
    logic                           w_sweep_end;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;
    assign w_rotate    = (r_state == S_LIST);
    assign w_sweep_end = w_rotate && (r_step == IDX_W'(N - 1));

    // incoming key is compared in the accept cycle
    assign w_cmp_key = '{file: i_req.file_number, page: i_req.page_number};

    // head of chain: new most recent entry, or ring wrap during a list
    assign w_head = w_rotate ? w_ent[N-1]
                             : lpts_pkg::t_entry'{valid: 1'b1, file: r_key.file,
                                                  page: r_key.page};

    // cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_first
            lpts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_nbr   (w_head),
                .i_key   (w_cmp_key),
                .o_ent   (w_ent[g]),
                .o_match (w_hit[g])
            );
        end else begin : g_rest
            lpts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_nbr   (w_ent[g-1]),
                .i_key   (w_cmp_key),
                .o_ent   (w_ent[g]),
                .o_match (w_hit[g])
            );
        end
        assign w_valid[g] = w_ent[g].valid;
        assign w_le[g]    = (CNT_W'(g) <= w_bound);
        assign w_ctl[g]   = '{shift: (w_upd && w_le[g]) || w_rotate, clear: w_drop};
    end

    // list sweep tracker
    lpts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   ((r_state == S_EXEC) && (r_func == lpts_pkg::FN_LIST)),
        .i_en    (w_rotate),
        .i_end   (w_sweep_end),
        .i_file  (r_key.file),
        .i_ent   (w_ent[N-1]),
        .o_res   (w_scan)
    );

    // matched cell position
    always_comb begin
        w_k = '0;
        for (int i = 0; i < N; i++) begin
            if (r_match[i]) begin
                w_k = w_k | IDX_W'(i);
            end
        end
    end
    assign w_any = |r_match;

    // effective capacity, clamped to 1..N
    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = CNT_W'(1);
        end else if (int'(r_cap) > N) begin
            w_cap_eff = CNT_W'(N);
        end else begin
            w_cap_eff = CNT_W'(r_cap);
        end
    end

    // least recent entry sits at the end of the valid run
    assign w_full   = (r_occ >= w_cap_eff) && (r_occ != '0);
    assign w_occ_m1 = r_occ - CNT_W'(1);
    assign w_victim = w_ent[w_occ_m1[IDX_W-1:0]];

    // chain update for the current function
    always_comb begin
        w_upd   = 1'b0;
        w_drop  = 1'b0;
        w_bound = r_occ;
        if (r_state == S_EXEC) begin
            case (r_func)
                lpts_pkg::FN_INSERT: begin
                    w_upd   = !w_any;
                    w_bound = w_full ? w_occ_m1 : r_occ;
                end
                lpts_pkg::FN_TOUCH: begin
                    w_upd   = w_any;
                    w_bound = CNT_W'(w_k);
                end
                lpts_pkg::FN_DROP: begin
                    w_drop = 1'b1;
                end
                default: begin
                    w_upd = 1'b0;
                end
            endcase
        end
    end

    // next state and response
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        n_func  = r_func;
        n_key   = r_key;
        n_match = r_match;
        n_occ   = r_occ;
        n_cap   = i_cfg_valid ? i_cfg_data : r_cap;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                    n_func  = i_req.func;
                    n_key   = w_cmp_key;
                    n_match = w_hit;
                end
            end
            S_EXEC: begin
                n_rsp      = '0;
                n_rsp.last = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
                case (r_func)
                    lpts_pkg::FN_LOOKUP: begin
                        n_rsp.hit = w_any;
                    end
                    lpts_pkg::FN_INSERT: begin
                        if (w_any) begin
                            n_rsp.status = lpts_pkg::ST_DUP;
                        end else if (w_full) begin
                            n_rsp.evicted  = 1'b1;
                            n_rsp.out_file = w_victim.file;
                            n_rsp.out_page = w_victim.page;
                        end else begin
                            n_occ = r_occ + CNT_W'(1);
                        end
                    end
                    lpts_pkg::FN_TOUCH: begin
                        if (!w_any) begin
                            n_rsp.status = lpts_pkg::ST_MISSING;
                        end
                    end
                    lpts_pkg::FN_LIST: begin
                        n_done  = 1'b0;
                        n_rsp   = r_rsp;
                        n_state = S_LIST;
                        n_step  = '0;
                    end
                    lpts_pkg::FN_DROP: begin
                        n_occ = '0;
                    end
                    default: begin
                        n_rsp.last = 1'b1;
                    end
                endcase
            end
            S_LIST: begin
                n_step = r_step + IDX_W'(1);
                if (w_sweep_end) begin
                    n_step         = '0;
                    n_done         = 1'b1;
                    n_rsp          = '0;
                    n_rsp.hit      = w_scan.found;
                    n_rsp.out_page = w_scan.found ? w_scan.page : '0;
                    n_rsp.last     = !w_scan.found || !w_scan.more;
                    if (n_rsp.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_occ   <= '0;
            r_cap   <= lpts_pkg::CAP_RESET;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_occ   <= n_occ;
            r_cap   <= n_cap;
            r_step  <= n_step;
        end
        r_rsp   <= n_rsp;
        r_func  <= n_func;
        r_key   <= n_key;
        r_match <= n_match;
    end

    // keys are unique, so at most one cell matches
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(r_match))
        else $error("more than one cell matched the key");

    // valid cells and occupancy agree whenever idle
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_valid) == int'(r_occ)))
        else $error("occupancy differs from valid cell count");

    // valid cells form one run from the most recent end
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((w_valid & (w_valid + N'(1))) == '0))
        else $error("valid cells are not contiguous");

    // busy only drops with a final result
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_done && o_rsp.last))
        else $error("busy fell without a final result");

    // a result that is not final keeps the block busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.last) |-> busy)
        else $error("non-final result while idle");

endmodule

### dv/lru_page_tag_store_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_tag_store_core_tb
// Self-checking bench for the LRU page tag store. A short directed table
// covers empty-store misses, key extremes, duplicates, missing touches,
// eviction order, out-of-range capacities and reserved function codes.
// Random phases at several capacities follow. Responses are checked against
// fixed table rows or a shadow copy of the directory and its recency ranks.
// ----------------------------------------------------------------------------
module lru_page_tag_store_core_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_LIST    = 32;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 42;
    localparam int FILE_POOL   = 4;
    localparam int PAGE_POOL   = 40;

    // function codes the block does not define
    localparam logic [lpts_pkg::FUNC_W-1:0] FN_RSVD_5 = 3'd5;
    localparam logic [lpts_pkg::FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [lpts_pkg::FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    lpts_pkg::t_req                 i_req;
    logic                           busy;
    logic                           o_done;
    lpts_pkg::t_rsp                 o_rsp;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [lpts_pkg::CFG_W-1:0]     i_cfg_data;

    // one row of the directed table
    typedef struct {
        bit                         is_cfg;
        logic [lpts_pkg::CFG_W-1:0] cap;
        lpts_pkg::t_req             req;
        bit                         fixed;
        lpts_pkg::t_rsp             rsp;
    } t_stim_row;

    t_stim_row directed_q [$];

    // shadow directory
    logic [lpts_pkg::KEY_W-1:0] shadow_file  [lpts_pkg::N_CELLS];
    logic [lpts_pkg::KEY_W-1:0] shadow_page  [lpts_pkg::N_CELLS];
    bit                         shadow_valid [lpts_pkg::N_CELLS];
    logic [lpts_pkg::IDX_W-1:0] shadow_rank  [lpts_pkg::N_CELLS];
    logic [lpts_pkg::CNT_W-1:0] shadow_count;
    logic [lpts_pkg::CFG_W-1:0] shadow_cap;

    lpts_pkg::t_rsp predicted_q   [$];
    lpts_pkg::t_rsp pending_rsp_q [$];

    // typed expectation travelling with the current request
    bit             row_fixed;
    lpts_pkg::t_rsp row_fixed_rsp;

    logic [lpts_pkg::KEY_W-1:0] file_pool [FILE_POOL];
    logic [lpts_pkg::KEY_W-1:0] page_pool [PAGE_POOL];
    int n_files;
    int n_pages;

    int err_count    = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;

    lru_page_tag_store_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int find_entry(input logic [lpts_pkg::KEY_W-1:0] f,
                                      input logic [lpts_pkg::KEY_W-1:0] p);
        for (int i = 0; i < lpts_pkg::N_CELLS; i++)
            if (shadow_valid[i] && shadow_file[i] == f && shadow_page[i] == p)
                return i;
        return -1;
    endfunction

    // responses of one request, applied to the shadow directory
    function automatic void predict_rsp(input lpts_pkg::t_req r);
        int                         slot;
        int                         n;
        bit                         found;
        bit                         have_prev;
        logic [lpts_pkg::KEY_W-1:0] best;
        logic [lpts_pkg::KEY_W-1:0] prev;
        logic [lpts_pkg::CNT_W-1:0] eff_cap;
        logic [lpts_pkg::IDX_W-1:0] rank;
        lpts_pkg::t_rsp             rsp;
        predicted_q.delete();
        rsp = '0;
        rsp.last = 1'b1;
        slot = find_entry(r.file_number, r.page_number);
        case (r.func)
            lpts_pkg::FN_LOOKUP: begin
                rsp.hit = (slot >= 0);
                predicted_q = {predicted_q, rsp};
            end
            lpts_pkg::FN_INSERT: begin
                if (shadow_cap == 0)
                    eff_cap = lpts_pkg::CNT_W'(1);
                else if (shadow_cap > lpts_pkg::N_CELLS)
                    eff_cap = lpts_pkg::CNT_W'(lpts_pkg::N_CELLS);
                else
                    eff_cap = lpts_pkg::CNT_W'(shadow_cap);
                if (slot >= 0) begin
                    rsp.status = lpts_pkg::ST_DUP;
                end else begin
                    // full store: least recent entry leaves first
                    if (shadow_count >= eff_cap && shadow_count > 0) begin
                        for (int i = 0; i < lpts_pkg::N_CELLS; i++)
                            if (slot < 0 && shadow_valid[i] && shadow_rank[i] == 0)
                                slot = i;
                        if (slot >= 0) begin
                            rsp.evicted  = 1'b1;
                            rsp.out_file = shadow_file[slot];
                            rsp.out_page = shadow_page[slot];
                            shadow_valid[slot] = 1'b0;
                            shadow_rank[slot]  = '0;
                            shadow_count--;
                            for (int i = 0; i < lpts_pkg::N_CELLS; i++)
                                if (shadow_valid[i] && shadow_rank[i] > 0)
                                    shadow_rank[i]--;
                        end
                    end
                    slot = -1;
                    for (int i = 0; i < lpts_pkg::N_CELLS; i++)
                        if (slot < 0 && !shadow_valid[i])
                            slot = i;
                    if (slot >= 0) begin
                        shadow_valid[slot] = 1'b1;
                        shadow_file[slot]  = r.file_number;
                        shadow_page[slot]  = r.page_number;
                        shadow_rank[slot]  = shadow_count[lpts_pkg::IDX_W-1:0];
                        shadow_count++;
                    end
                end
                predicted_q = {predicted_q, rsp};
            end
            lpts_pkg::FN_TOUCH: begin
                if (slot < 0) begin
                    rsp.status = lpts_pkg::ST_MISSING;
                end else begin
                    // move to most recent, close the gap behind it
                    rank = shadow_rank[slot];
                    for (int i = 0; i < lpts_pkg::N_CELLS; i++)
                        if (shadow_valid[i] && shadow_rank[i] > rank)
                            shadow_rank[i]--;
                    shadow_rank[slot] = lpts_pkg::IDX_W'(shadow_count - 1);
                end
                predicted_q = {predicted_q, rsp};
            end
            lpts_pkg::FN_LIST: begin
                // pages of the file in ascending order
                n = 0;
                have_prev = 1'b0;
                prev = '0;
                found = 1'b1;
                while (found && n < MAX_LIST) begin
                    found = 1'b0;
                    best = '0;
                    for (int i = 0; i < lpts_pkg::N_CELLS; i++)
                        if (shadow_valid[i] && shadow_file[i] == r.file_number &&
                            (!have_prev || shadow_page[i] > prev) &&
                            (!found || shadow_page[i] < best)) begin
                            best  = shadow_page[i];
                            found = 1'b1;
                        end
                    if (found) begin
                        rsp = '0;
                        rsp.hit = 1'b1;
                        rsp.out_page = best;
                        predicted_q = {predicted_q, rsp};
                        n++;
                        prev = best;
                        have_prev = 1'b1;
                    end
                end
                if (n == 0) begin
                    rsp = '0;
                    rsp.last = 1'b1;
                    predicted_q = {predicted_q, rsp};
                end else begin
                    predicted_q[predicted_q.size() - 1].last = 1'b1;
                end
            end
            lpts_pkg::FN_DROP: begin
                for (int i = 0; i < lpts_pkg::N_CELLS; i++) begin
                    shadow_valid[i] = 1'b0;
                    shadow_rank[i]  = '0;
                end
                shadow_count = '0;
                predicted_q = {predicted_q, rsp};
            end
            default: begin
                predicted_q = {predicted_q, rsp};
            end
        endcase
    endfunction

    function automatic string fmt_rsp(input lpts_pkg::t_rsp r);
        return $sformatf("hit=%b ev=%b file=%h page=%h st=%0d last=%b",
                         r.hit, r.evicted, r.out_file, r.out_page, r.status, r.last);
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // response check, request capture and register shadow
    always @(posedge i_clk) begin : monitor
        lpts_pkg::t_rsp want;
        bit             moved;
        if (i_rst_n === 1'b1) begin
            moved = 1'b0;
            if (o_done === 1'b1) begin
                moved = 1'b1;
                if (pending_rsp_q.size() == 0) begin
                    report_mismatch({"unexpected response ", fmt_rsp(o_rsp)});
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (o_rsp !== want)
                        report_mismatch({"got ", fmt_rsp(o_rsp), " expected ",
                                         fmt_rsp(want)});
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                moved = 1'b1;
                predict_rsp(i_req);
                if (row_fixed)
                    pending_rsp_q = {pending_rsp_q, row_fixed_rsp};
                else
                    foreach (predicted_q[k])
                        pending_rsp_q = {pending_rsp_q, predicted_q[k]};
            end
            if (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1) begin
                moved = 1'b1;
                shadow_cap = i_cfg_data;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // present one request and hold it until accepted
    task automatic issue(input lpts_pkg::t_req r, input bit fixed,
                         input lpts_pkg::t_rsp fx);
        start         <= 1'b1;
        i_req         <= r;
        row_fixed     <= fixed;
        row_fixed_rsp <= fx;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // bursts of back-to-back requests with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // wait until every pending response has arrived
    task automatic drain();
        if (start !== 1'b0)
            start <= 1'b0;
        while (pending_rsp_q.size() != 0 || busy !== 1'b0)
            @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [lpts_pkg::CFG_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic lpts_pkg::t_rsp done_rsp(input logic hit, input logic ev,
                                                input logic [lpts_pkg::KEY_W-1:0] f,
                                                input logic [lpts_pkg::KEY_W-1:0] p,
                                                input logic [lpts_pkg::STAT_W-1:0] st);
        lpts_pkg::t_rsp r;
        r = '{hit: hit, evicted: ev, out_file: f, out_page: p, status: st, last: 1'b1};
        return r;
    endfunction

    function automatic void add_req(input logic [lpts_pkg::FUNC_W-1:0] fn,
                                    input logic [lpts_pkg::KEY_W-1:0] f,
                                    input logic [lpts_pkg::KEY_W-1:0] p);
        t_stim_row row;
        row = '{is_cfg: 1'b0, cap: '0, req: '{func: fn, file_number: f, page_number: p},
                fixed: 1'b0, rsp: '0};
        directed_q = {directed_q, row};
    endfunction

    function automatic void add_fixed(input logic [lpts_pkg::FUNC_W-1:0] fn,
                                      input logic [lpts_pkg::KEY_W-1:0] f,
                                      input logic [lpts_pkg::KEY_W-1:0] p,
                                      input lpts_pkg::t_rsp want);
        t_stim_row row;
        row = '{is_cfg: 1'b0, cap: '0, req: '{func: fn, file_number: f, page_number: p},
                fixed: 1'b1, rsp: want};
        directed_q = {directed_q, row};
    endfunction

    function automatic void add_cfg(input logic [lpts_pkg::CFG_W-1:0] v);
        t_stim_row row;
        row = '{is_cfg: 1'b1, cap: v, req: '0, fixed: 1'b0, rsp: '0};
        directed_q = {directed_q, row};
    endfunction

    function automatic logic [lpts_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return lpts_pkg::KEY_W'($urandom_range(0, 15));
            1:       return ~lpts_pkg::KEY_W'($urandom_range(0, 15));
            default: return lpts_pkg::KEY_W'($urandom);
        endcase
    endfunction

    // mostly pool keys so that hits happen, some noise keys and reserved codes
    function automatic lpts_pkg::t_req random_request();
        lpts_pkg::t_req r;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        r.file_number = file_pool[$urandom_range(0, n_files - 1)];
        r.page_number = page_pool[$urandom_range(0, n_pages - 1)];
        if (pick < 35)
            r.func = lpts_pkg::FN_INSERT;
        else if (pick < 55)
            r.func = lpts_pkg::FN_LOOKUP;
        else if (pick < 75)
            r.func = lpts_pkg::FN_TOUCH;
        else if (pick < 87)
            r.func = lpts_pkg::FN_LIST;
        else if (pick < 90)
            r.func = lpts_pkg::FN_DROP;
        else if (pick < 93)
            r.func = lpts_pkg::FUNC_W'($urandom_range(FN_RSVD_5, FN_RSVD_7));
        else begin
            r.func = pick[0] ? lpts_pkg::FN_LOOKUP : lpts_pkg::FN_TOUCH;
            r.file_number = $urandom;
            r.page_number = $urandom;
        end
        return r;
    endfunction

    initial begin : stimulus
        logic [lpts_pkg::CFG_W-1:0] cap;
        int                         fill;
        lpts_pkg::t_req             r;
        start         <= 1'b0;
        i_req         <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        row_fixed     <= 1'b0;
        row_fixed_rsp <= '0;
        for (int i = 0; i < lpts_pkg::N_CELLS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
            shadow_file[i]  = '0;
            shadow_page[i]  = '0;
        end
        shadow_count = '0;
        shadow_cap   = lpts_pkg::CAP_RESET;

        // directed table
        add_fixed(lpts_pkg::FN_LOOKUP, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_TOUCH, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_MISSING));
        add_fixed(lpts_pkg::FN_LIST, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, '1, '1,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_DUP));
        add_fixed(lpts_pkg::FN_LOOKUP, '1, '1,
                  done_rsp(1'b1, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, '0, '1,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, '0, 32'd7,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_req(lpts_pkg::FN_LIST, '0, '1);
        add_req(lpts_pkg::FN_LIST, '1, '0);
        add_fixed(lpts_pkg::FN_TOUCH, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(FN_RSVD_5, '1, '1, done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(FN_RSVD_6, '0, '0, done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(FN_RSVD_7, '1, '0, done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_DROP, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_LOOKUP, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        // eviction order at a small capacity
        add_cfg(6'd2);
        add_fixed(lpts_pkg::FN_INSERT, 32'd1, 32'd10,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, 32'd1, 32'd20,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_INSERT, 32'd1, 32'd30,
                  done_rsp(1'b0, 1'b1, 32'd1, 32'd10, lpts_pkg::ST_OK));
        add_fixed(lpts_pkg::FN_TOUCH, 32'd1, 32'd20,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));
        add_req(lpts_pkg::FN_INSERT, 32'd1, 32'd40);
        // zero capacity acts as one, with the store over capacity
        add_cfg(6'd0);
        add_req(lpts_pkg::FN_INSERT, 32'd2, 32'd1);
        // capacity above the cell count
        add_cfg('1);
        add_req(lpts_pkg::FN_LIST, 32'd1, '0);
        add_req(lpts_pkg::FN_LIST, 32'd2, '0);
        add_fixed(lpts_pkg::FN_DROP, '0, '0,
                  done_rsp(1'b0, 1'b0, '0, '0, lpts_pkg::ST_OK));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[k]) begin
            if (directed_q[k].is_cfg) begin
                write_capacity(directed_q[k].cap);
            end else begin
                issue(directed_q[k].req, directed_q[k].fixed, directed_q[k].rsp);
                pace();
            end
        end

        // random phases, each starting with a capacity write
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0, N_PHASES - 1: cap = lpts_pkg::CFG_W'(lpts_pkg::N_CELLS);
                1:       cap = 6'd1;
                2:       cap = 6'd0;
                3:       cap = '1;
                5:       cap = 6'd2;
                default: cap = lpts_pkg::CFG_W'($urandom_range(1, lpts_pkg::N_CELLS));
            endcase
            write_capacity(cap);
            if (phase == 0 || phase == N_PHASES - 1) begin
                n_files = 1;
                n_pages = PAGE_POOL;
                fill    = 38;
            end else begin
                n_files = $urandom_range(1, FILE_POOL);
                n_pages = $urandom_range(4, 24);
                fill    = $urandom_range(0, 20);
            end
            for (int i = 0; i < FILE_POOL; i++)
                file_pool[i] = pick_key();
            for (int i = 0; i < PAGE_POOL; i++)
                page_pool[i] = pick_key();

            // fill pass walking the page pool
            for (int k = 0; k < fill; k++) begin
                r = '{func: lpts_pkg::FN_INSERT,
                      file_number: file_pool[$urandom_range(0, n_files - 1)],
                      page_number: page_pool[k % n_pages]};
                issue(r, 1'b0, '0);
                pace();
            end
            drain();

            for (int k = fill; k < PHASE_ITEMS; k++) begin
                issue(random_request(), 1'b0, '0);
                pace();
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### lru_page_tag_store_core.f
rtl/lpts_pkg.sv
rtl/lpts_cell.sv
rtl/lpts_scan.sv
rtl/lru_page_tag_store_core.sv
dv/lru_page_tag_store_core_tb.sv
